### hw/rtl/dvrt_pkg.sv
// shared types and constants for the distance-vector route table
// no dependencies; used by the cell, the controller, the top level and the testbench

package dvrt_pkg;

    localparam int MAX_ENTRIES_DEF = 32;

    typedef enum logic [1:0] {
        REQ_UPDATE = 2'd0,
        REQ_ADD    = 2'd1,
        REQ_LOOKUP = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } ctrl_state_t;

    // one stored route
    typedef struct packed {
        logic [7:0] dest;
        logic [7:0] next;
        logic [7:0] metric;
        logic [7:0] seq;
    } dvrt_ent_t;

    // request token walking down the row of cells
    typedef struct packed {
        logic       valid;
        req_kind_t  req;
        logic [7:0] dest;
        logic [7:0] via;
        logic [7:0] metric;
        logic [7:0] seq;
        logic       hit;
        logic       changed;
        logic [7:0] next_hop;
    } dvrt_tok_t;

endpackage

### hw/rtl/dvrt_if.sv
// request and response channel interfaces with valid/ready handshake
// depends on nothing; a beat moves when valid and ready are both high

interface dvrt_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] dest_node;
    logic [7:0] via_node;
    logic [7:0] adv_metric;
    logic [7:0] adv_seq;

    modport source (
        output valid, req_type, dest_node, via_node, adv_metric, adv_seq,
        input  ready
    );
    modport sink (
        input  valid, req_type, dest_node, via_node, adv_metric, adv_seq,
        output ready
    );
endinterface

interface dvrt_rsp_if;
    logic       valid;
    logic       ready;
    logic       changed;
    logic       found;
    logic [7:0] next_hop;
    logic       table_full;

    modport source (
        output valid, changed, found, next_hop, table_full,
        input  ready
    );
    modport sink (
        input  valid, changed, found, next_hop, table_full,
        output ready
    );
endinterface

### hw/rtl/dvrt_cell.sv
// one route cell: holds a single entry and passes the request token to its neighbor
// depends on dvrt_pkg

module dvrt_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                live,
    input  dvrt_pkg::dvrt_tok_t tok_in,
    output dvrt_pkg::dvrt_tok_t tok_out,
    input  logic                wr_en,
    input  dvrt_pkg::dvrt_ent_t wr_ent
);

    dvrt_pkg::dvrt_ent_t ent_reg;
    dvrt_pkg::dvrt_ent_t ent_next;
    dvrt_pkg::dvrt_tok_t tok_reg;
    dvrt_pkg::dvrt_tok_t tok_next;
    logic                match;
    logic                better;

    always_comb
    begin
        tok_next = tok_in;
        ent_next = ent_reg;
        // only the first live match along the row takes the request
        match = tok_in.valid && !tok_in.hit && live && (ent_reg.dest == tok_in.dest) &&
                ((tok_in.req == dvrt_pkg::REQ_UPDATE) || (tok_in.req == dvrt_pkg::REQ_LOOKUP));
        better = (ent_reg.seq < tok_in.seq) ||
                 ((ent_reg.seq == tok_in.seq) && (ent_reg.metric > tok_in.metric));
        if (match)
        begin
            tok_next.hit = 1'b1;
            if (tok_in.req == dvrt_pkg::REQ_LOOKUP)
            begin
                tok_next.next_hop = ent_reg.next;
            end
            else if (better)
            begin
                ent_next.next    = tok_in.via;
                ent_next.metric  = tok_in.metric;
                ent_next.seq     = tok_in.seq;
                tok_next.changed = 1'b1;
            end
        end
        if (wr_en)
        begin
            ent_next = wr_ent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign tok_out = tok_reg;

endmodule

### hw/rtl/dvrt_ctrl.sv
// controller: takes request beats, launches tokens into the cell row,
// appends new routes, keeps the entry count and holds the response; depends on dvrt_pkg, dvrt_if

module dvrt_ctrl
#(
    parameter  int MAX_ENTRIES = dvrt_pkg::MAX_ENTRIES_DEF,
    localparam int CW          = $clog2(MAX_ENTRIES + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    dvrt_req_if.sink               req,
    dvrt_rsp_if.source             rsp,
    output dvrt_pkg::dvrt_tok_t    launch_tok,
    input  dvrt_pkg::dvrt_tok_t    chain_tok,
    output logic [CW-1:0]          count,
    output logic [MAX_ENTRIES-1:0] wr_sel,
    output dvrt_pkg::dvrt_ent_t    wr_ent
);

    dvrt_pkg::ctrl_state_t state_reg;
    dvrt_pkg::ctrl_state_t state_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    dvrt_pkg::dvrt_tok_t   launch_reg;
    dvrt_pkg::dvrt_tok_t   launch_next;
    logic                  changed_reg;
    logic                  found_reg;
    logic [7:0]            next_hop_reg;
    logic                  full_reg;
    logic                  in_ready;
    logic                  accept;
    logic                  room;
    logic                  need_append;
    logic                  do_append;
    logic [7:0]            hop;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        rsp.valid  = 1'b0;
        case (state_reg)
            dvrt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (req.valid)
                begin
                    state_next = dvrt_pkg::ST_SCAN;
                end
            end
            dvrt_pkg::ST_SCAN:
            begin
                if (chain_tok.valid)
                begin
                    state_next = dvrt_pkg::ST_DONE;
                end
            end
            dvrt_pkg::ST_DONE:
            begin
                rsp.valid = 1'b1;
                in_ready  = rsp.ready;
                if (rsp.ready)
                begin
                    state_next = req.valid ? dvrt_pkg::ST_SCAN : dvrt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dvrt_pkg::ST_IDLE;
            end
        endcase
    end

    assign req.ready = in_ready;
    assign accept    = req.valid && in_ready;

    // saturating metric plus one for advertised entries
    assign hop = (req.adv_metric == 8'hFF) ? 8'hFF : (req.adv_metric + 8'd1);

    always_comb
    begin
        launch_next          = launch_reg;
        launch_next.valid    = accept;
        if (accept)
        begin
            launch_next.req      = dvrt_pkg::req_kind_t'(req.req_type);
            launch_next.dest     = req.dest_node;
            launch_next.via      = req.via_node;
            launch_next.metric   = (dvrt_pkg::req_kind_t'(req.req_type) == dvrt_pkg::REQ_UPDATE)
                                   ? hop : req.adv_metric;
            launch_next.seq      = req.adv_seq;
            launch_next.hit      = 1'b0;
            launch_next.changed  = 1'b0;
            launch_next.next_hop = 8'd0;
        end
    end

    assign room        = (count_reg < CW'(MAX_ENTRIES));
    assign need_append = chain_tok.valid &&
                         (((chain_tok.req == dvrt_pkg::REQ_UPDATE) && !chain_tok.hit) ||
                          (chain_tok.req == dvrt_pkg::REQ_ADD));
    assign do_append   = need_append && room;

    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            wr_sel[i] = do_append && (count_reg == CW'(i));
        end
    end

    assign wr_ent.dest   = chain_tok.dest;
    assign wr_ent.next   = chain_tok.via;
    assign wr_ent.metric = chain_tok.metric;
    assign wr_ent.seq    = chain_tok.seq;

    always_comb
    begin
        count_next = count_reg;
        if (chain_tok.valid && (chain_tok.req == dvrt_pkg::REQ_CLEAR))
        begin
            count_next = '0;
        end
        else if (do_append)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= dvrt_pkg::ST_IDLE;
            count_reg  <= '0;
            launch_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            launch_reg <= launch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chain_tok.valid)
        begin
            changed_reg  <= chain_tok.changed || do_append;
            found_reg    <= (chain_tok.req == dvrt_pkg::REQ_LOOKUP) && chain_tok.hit;
            next_hop_reg <= chain_tok.next_hop;
            full_reg     <= need_append && !room;
        end
    end

    assign rsp.changed    = changed_reg;
    assign rsp.found      = found_reg;
    assign rsp.next_hop   = next_hop_reg;
    assign rsp.table_full = full_reg;
    assign launch_tok     = launch_reg;
    assign count          = count_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ENTRIES))
        else $error("entry count beyond table size");

    a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chain_tok.valid |-> (state_reg == dvrt_pkg::ST_SCAN))
        else $error("token left the row outside a scan");

    a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.table_full) |-> (count_reg == CW'(MAX_ENTRIES)))
        else $error("table_full reported with free entries");

    a_no_change_and_find: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.changed && (rsp.found || rsp.table_full)))
        else $error("conflicting response flags");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        do_append |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("append did not advance entry count");
`endif

endmodule

### hw/rtl/distance_vector_route_table.sv
// top level of the distance-vector route table: controller plus a row of route cells
// depends on dvrt_pkg, dvrt_if, dvrt_cell, dvrt_ctrl
//
// usage:
//   req carries one request beat (update, raw add, lookup, clear); rsp returns
//   exactly one response beat per request with changed, found, next_hop, table_full.
//   each stored route lives in its own cell; a request token steps one cell per
//   cycle down the row, so the first live match decides an update or a lookup.
//   a request is registered as the launch token, then passes the token register of
//   every cell in the row; the controller registers the response flags as the token
//   leaves the row. only one request is in flight at a time; a new request is
//   taken in the same cycle the pending response beat is taken.
//   reset: entry count returns to zero, no request is in flight and no response
//   is pending; stored routes are not cleared, only entries below the count are read.
//   a stalled receiver holds the response steady and blocks new requests.

module distance_vector_route_table
#(
    parameter  int MAX_ENTRIES = dvrt_pkg::MAX_ENTRIES_DEF,
    localparam int CW          = $clog2(MAX_ENTRIES + 1)
)
(
    input  logic       clk,
    input  logic       rst_n,
    dvrt_req_if.sink   req,
    dvrt_rsp_if.source rsp
);

    dvrt_pkg::dvrt_tok_t   tok_chain [MAX_ENTRIES+1];
    logic [CW-1:0]         count;
    logic [MAX_ENTRIES-1:0] wr_sel;
    dvrt_pkg::dvrt_ent_t   wr_ent;

    dvrt_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .launch_tok (tok_chain[0]),
        .chain_tok  (tok_chain[MAX_ENTRIES]),
        .count      (count),
        .wr_sel     (wr_sel),
        .wr_ent     (wr_ent)
    );

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        logic live;

        assign live = (CW'(i) < count);

        dvrt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .live    (live),
            .tok_in  (tok_chain[i]),
            .tok_out (tok_chain[i+1]),
            .wr_en   (wr_sel[i]),
            .wr_ent  (wr_ent)
        );
    end

endmodule

### tb/dvrt_route_checker.sv
`timescale 1ns / 100ps
// route table checker: watches the request and response channels, keeps its own
// copy of the route table and compares every response beat against it
// depends on dvrt_pkg and the channel interfaces in dvrt_if

module dvrt_route_checker
(
    input  logic clk,
    input  logic rst_n,
    dvrt_req_if  req,
    dvrt_rsp_if  rsp,
    output int   errors,
    output int   pending
);

    localparam int ROUTES = dvrt_pkg::MAX_ENTRIES_DEF;

    typedef struct packed {
        logic       changed;
        logic       found;
        logic [7:0] next_hop;
        logic       table_full;
    } route_reply_t;

    logic [7:0]   known_dest   [ROUTES];
    logic [7:0]   known_next   [ROUTES];
    logic [7:0]   known_metric [ROUTES];
    logic [7:0]   known_seq    [ROUTES];
    int           route_count;
    route_reply_t replies_due [$];

    initial errors = 0;

    // first stored route for a destination, -1 when there is none
    function automatic int first_route(input logic [7:0] dest);
        for (int i = 0; i < route_count; i++)
        begin
            if (known_dest[i] == dest)
                return i;
        end
        return -1;
    endfunction

    function automatic bit append_route(input logic [7:0] dest, input logic [7:0] via,
                                        input logic [7:0] metric, input logic [7:0] seq);
        if (route_count >= ROUTES)
            return 1'b0;
        known_dest[route_count]   = dest;
        known_next[route_count]   = via;
        known_metric[route_count] = metric;
        known_seq[route_count]    = seq;
        route_count++;
        return 1'b1;
    endfunction

    function automatic route_reply_t apply_request(input dvrt_pkg::req_kind_t kind,
                                                   input logic [7:0] dest,
                                                   input logic [7:0] via,
                                                   input logic [7:0] metric,
                                                   input logic [7:0] seq);
        route_reply_t reply;
        logic [7:0]   hop;
        int           k;
        reply = '0;
        hop = (metric == 8'hFF) ? 8'hFF : metric + 8'd1;
        case (kind)
            dvrt_pkg::REQ_UPDATE:
            begin
                k = first_route(dest);
                if (k >= 0)
                begin
                    // newer sequence always wins, equal sequence only with a shorter path
                    if (known_seq[k] < seq)
                    begin
                        known_next[k]   = via;
                        known_metric[k] = hop;
                        known_seq[k]    = seq;
                        reply.changed   = 1'b1;
                    end
                    else if (known_seq[k] == seq && known_metric[k] > hop)
                    begin
                        known_next[k]   = via;
                        known_metric[k] = hop;
                        reply.changed   = 1'b1;
                    end
                end
                else if (append_route(dest, via, hop, seq))
                    reply.changed = 1'b1;
                else
                    reply.table_full = 1'b1;
            end
            dvrt_pkg::REQ_ADD:
            begin
                if (append_route(dest, via, metric, seq))
                    reply.changed = 1'b1;
                else
                    reply.table_full = 1'b1;
            end
            dvrt_pkg::REQ_LOOKUP:
            begin
                k = first_route(dest);
                if (k >= 0)
                begin
                    reply.found    = 1'b1;
                    reply.next_hop = known_next[k];
                end
            end
            default:
                route_count = 0;
        endcase
        return reply;
    endfunction

    task automatic report_mismatch(input string field, input int want, input int got);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        route_reply_t got;
        route_reply_t want;
        if (!rst_n)
        begin
            replies_due.delete();
            route_count = 0;
            pending = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got = '{rsp.changed, rsp.found, rsp.next_hop, rsp.table_full};
                if (replies_due.size() == 0)
                begin
                    $display("%0t: response beat with nothing expected, got %0h", $time, got);
                    errors++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (got.changed !== want.changed)
                        report_mismatch("changed", int'(want.changed), int'(got.changed));
                    if (got.found !== want.found)
                        report_mismatch("found", int'(want.found), int'(got.found));
                    if (got.next_hop !== want.next_hop)
                        report_mismatch("next_hop", int'(want.next_hop), int'(got.next_hop));
                    if (got.table_full !== want.table_full)
                        report_mismatch("table_full", int'(want.table_full),
                                        int'(got.table_full));
                end
            end
            if (req.valid && req.ready)
                replies_due.insert(replies_due.size(),
                                   apply_request(dvrt_pkg::req_kind_t'(req.req_type),
                                                 req.dest_node, req.via_node,
                                                 req.adv_metric, req.adv_seq));
            pending = replies_due.size();
        end
    end

endmodule

### tb/distance_vector_route_table_tb.sv
`timescale 1ns / 100ps
// top of the route table testbench: clock, reset, request stimulus, response stalls
// and the verdict; depends on dvrt_pkg, dvrt_if, the block and dvrt_route_checker

module distance_vector_route_table_tb;

    localparam int ITEM_TARGET = 1200;
    localparam int CALM_TAIL   = 150;
    localparam int STUCK_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 40;

    logic clk;
    logic rst_n;
    bit   idle_on;
    int   items_sent;
    int   stall_left;
    int   stuck_cycles;
    int   mismatch_count;
    int   pending_count;

    dvrt_req_if req_ch ();
    dvrt_rsp_if rsp_ch ();

    distance_vector_route_table dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    dvrt_route_checker chk
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .errors  (mismatch_count),
        .pending (pending_count)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // response side: random stall bursts while idling is on
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left = $urandom_range(1, 11) - 1;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("distance_vector_route_table_tb: done, errors");
                $finish;
            end
        end
    end

    // drive one request beat and return at the falling edge after it is taken
    task automatic issue_request(input dvrt_pkg::req_kind_t kind, input logic [7:0] dest,
                                 input logic [7:0] via, input logic [7:0] metric,
                                 input logic [7:0] seq);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.dest_node  <= dest;
        req_ch.via_node   <= via;
        req_ch.adv_metric <= metric;
        req_ch.adv_seq    <= seq;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // one clear followed by traffic on a small set of destinations, so that
    // updates hit stored routes and some sets overflow the table
    task automatic run_episode(input int n_items);
        logic [7:0] pool_dest [64];
        logic [7:0] pool_seq  [64];
        logic [7:0] metric;
        logic [7:0] seq;
        logic [7:0] rnd_dest;
        logic [7:0] rnd_via;
        logic [7:0] rnd_metric;
        logic [7:0] rnd_seq;
        int         pool_size;
        int         add_pct;
        int         pick;
        int         roll;
        pool_size = $urandom_range(2, 64);
        add_pct   = $urandom_range(5, 40);
        for (int k = 0; k < pool_size; k++)
        begin
            pool_dest[k] = 8'($urandom);
            pool_seq[k]  = 8'($urandom);
        end
        issue_request(dvrt_pkg::REQ_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom));
        for (int k = 0; k < n_items; k++)
        begin
            pick       = $urandom_range(0, pool_size - 1);
            roll       = $urandom_range(0, 99);
            rnd_dest   = 8'($urandom);
            rnd_via    = 8'($urandom);
            rnd_metric = 8'($urandom);
            rnd_seq    = 8'($urandom);
            case ($urandom_range(0, 7))
                0:       metric = 8'hFF;
                1:       metric = 8'hFE;
                2:       metric = 8'h00;
                3, 4, 5: metric = 8'($urandom_range(0, 15));
                default: metric = 8'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: seq = pool_seq[pick];
                5, 6:
                begin
                    seq = pool_seq[pick] + 8'd1;
                    pool_seq[pick] = seq;
                end
                7:       seq = pool_seq[pick] - 8'd1;
                default: seq = 8'($urandom);
            endcase
            if (roll < add_pct)
                issue_request(dvrt_pkg::REQ_ADD, pool_dest[pick], rnd_via, metric, seq);
            else if (roll < add_pct + 40)
                issue_request(dvrt_pkg::REQ_UPDATE, pool_dest[pick], rnd_via, metric, seq);
            else if (roll < add_pct + 70)
                issue_request(dvrt_pkg::REQ_LOOKUP, pool_dest[pick], rnd_via, rnd_metric,
                              rnd_seq);
            else if (roll < add_pct + 75)
                issue_request(dvrt_pkg::REQ_LOOKUP, rnd_dest, rnd_via, rnd_metric, rnd_seq);
            else if (roll < add_pct + 80)
                issue_request(dvrt_pkg::REQ_UPDATE, rnd_dest, rnd_via, rnd_metric, rnd_seq);
            else if (roll < add_pct + 82)
                issue_request(dvrt_pkg::REQ_CLEAR, rnd_dest, rnd_via, rnd_metric, rnd_seq);
            else
                issue_request(dvrt_pkg::REQ_UPDATE, pool_dest[pick], rnd_via, metric, seq);
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        idle_on           = 1'b0;
        items_sent        = 0;
        stall_left        = 0;
        stuck_cycles      = 0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = dvrt_pkg::REQ_UPDATE;
        req_ch.dest_node  = 8'h00;
        req_ch.via_node   = 8'h00;
        req_ch.adv_metric = 8'h00;
        req_ch.adv_seq    = 8'h00;
        rsp_ch.ready      = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        idle_on = 1'b1;
        issue_request(dvrt_pkg::REQ_LOOKUP, 8'h00, 8'h00, 8'h00, 8'h00);  // empty table miss
        issue_request(dvrt_pkg::REQ_UPDATE, 8'hFF, 8'h00, 8'h00, 8'hFF);
        issue_request(dvrt_pkg::REQ_UPDATE, 8'h00, 8'hFF, 8'hFF, 8'h00);  // hop saturates
        issue_request(dvrt_pkg::REQ_LOOKUP, 8'hFF, 8'h00, 8'h00, 8'h00);  // hit, next hop 0
        issue_request(dvrt_pkg::REQ_UPDATE, 8'hFF, 8'h12, 8'h00, 8'hFF);  // same seq, same hop
        issue_request(dvrt_pkg::REQ_UPDATE, 8'h00, 8'h34, 8'hFE, 8'h00);  // 255 not shorter
        issue_request(dvrt_pkg::REQ_UPDATE, 8'h00, 8'h34, 8'h10, 8'h00);  // same seq, shorter
        issue_request(dvrt_pkg::REQ_UPDATE, 8'h00, 8'h56, 8'h80, 8'h01);  // newer seq, longer
        issue_request(dvrt_pkg::REQ_UPDATE, 8'hFF, 8'h77, 8'h00, 8'h00);  // older seq, no wrap
        issue_request(dvrt_pkg::REQ_ADD,    8'h00, 8'hAA, 8'hFF, 8'h55);  // duplicate dest
        issue_request(dvrt_pkg::REQ_LOOKUP, 8'h00, 8'hFF, 8'hFF, 8'hFF);  // lowest entry wins
        issue_request(dvrt_pkg::REQ_UPDATE, 8'h00, 8'h99, 8'h00, 8'h02);
        issue_request(dvrt_pkg::REQ_LOOKUP, 8'h00, 8'h00, 8'h00, 8'h00);
        issue_request(dvrt_pkg::REQ_ADD,    8'h5A, 8'hA5, 8'h00, 8'h00);
        issue_request(dvrt_pkg::REQ_LOOKUP, 8'hA5, 8'h5A, 8'h00, 8'h00);
        issue_request(dvrt_pkg::REQ_CLEAR,  8'hFF, 8'hFF, 8'hFF, 8'hFF);
        issue_request(dvrt_pkg::REQ_LOOKUP, 8'h00, 8'h00, 8'h00, 8'h00);  // stale entry unseen
        issue_request(dvrt_pkg::REQ_ADD,    8'h00, 8'hFF, 8'hFF, 8'hFF);
        issue_request(dvrt_pkg::REQ_LOOKUP, 8'h00, 8'h00, 8'h00, 8'h00);
        issue_request(dvrt_pkg::REQ_CLEAR,  8'h00, 8'h00, 8'h00, 8'h00);

        while (items_sent < ITEM_TARGET)
        begin
            idle_on = (items_sent < ITEM_TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            run_episode($urandom_range(10, 90));
        end
        req_ch.valid <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("distance_vector_route_table_tb: done, clean");
        else
            $display("distance_vector_route_table_tb: done, errors");
        $finish;
    end

endmodule

### sim.f
hw/rtl/dvrt_pkg.sv
hw/rtl/dvrt_if.sv
hw/rtl/dvrt_cell.sv
hw/rtl/dvrt_ctrl.sv
hw/rtl/distance_vector_route_table.sv
tb/dvrt_route_checker.sv
tb/distance_vector_route_table_tb.sv
